// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_cursor, text_console_writer, tcw_checker and tb.
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int POS_OUT_W  = 11;
  localparam int ADDR_IN_W  = 11;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CHAR_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] read_address;
  } in_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] cursor_position;
    logic [CELL_W-1:0]    cell_value;
  } out_t;

  // cursor update request, applied at the next clock edge
  typedef struct packed {
    logic adv;
    logic nl;
    logic home;
  } cur_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Text console writer top level: screen memory, command sequencer, output register.
// Depends on tcw_pkg and tcw_cursor.
`default_nettype none

// A command is taken when start is high and busy is low; its result word
// appears on out_word for one cycle with out_valid, and must be taken then.
// A put of an ordinary character, a newline above the last row, and the
// unused mode each answer in the next cycle; a cell read goes through the
// synchronous memory read register and then the output register. Clear and
// a newline on the last row (scroll) walk the whole screen memory one cell
// per cycle through its single write port with busy high, and the result
// comes in the first cycle with busy low. After reset the block runs a
// clearing pass with busy high; configuration writes are taken at any time.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                in_word,
  output logic                    out_valid,
  output out_t                    out_word,
  input  wire logic               cfg_we,
  input  wire logic [ATTR_W-1:0]  cfg_data
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int RA_W       = (AW > ADDR_IN_W) ? AW : ADDR_IN_W;
  localparam int SCROLL_LIM = CELLS - COLUMNS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     sw_r, sw_nxt;
  logic              sc_r, sc_nxt;
  logic              emit_r, emit_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic              p_v_r, p_v_nxt;
  logic [AW-1:0]     p_a_r, p_a_nxt;
  logic              p_z_r, p_z_nxt;
  logic              oob_r, oob_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  logic              accept;
  logic              is_nl;
  logic [RA_W-1:0]   rd_ext;
  logic              oob_in;
  logic              re;
  logic [AW-1:0]     raddr;
  logic              put_we;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              load_out;
  logic [CELL_W-1:0] rd_cell;

  cur_cmd_t          cmd;
  logic [AW-1:0]     pos_cur;
  logic [AW-1:0]     pos_nxt;
  logic              last_row;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .pos_cur  (pos_cur),
    .pos_nxt  (pos_nxt),
    .last_row (last_row)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);
  assign is_nl  = (in_word.char_code == NEWLINE_CODE);
  assign rd_ext = RA_W'(in_word.read_address);
  assign oob_in = (rd_ext >= RA_W'(CELLS));

  always_comb begin
    state_nxt     = state_r;
    sw_nxt        = sw_r;
    sc_nxt        = sc_r;
    emit_nxt      = emit_r;
    fill_nxt      = fill_r;
    p_v_nxt       = p_v_r;
    p_a_nxt       = p_a_r;
    p_z_nxt       = p_z_r;
    oob_nxt       = oob_r;
    cmd           = '0;
    put_we        = 1'b0;
    re            = 1'b0;
    raddr         = rd_ext[AW-1:0];
    load_out      = 1'b0;
    rd_cell       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.mode)
            MODE_PUT: begin
              if (is_nl) begin
                cmd.nl = 1'b1;
                if (last_row) begin
                  // scroll: move rows up, zero the last row
                  state_nxt = ST_SWEEP;
                  sw_nxt    = '0;
                  sc_nxt    = 1'b1;
                  emit_nxt  = 1'b1;
                end else begin
                  load_out = 1'b1;
                end
              end else begin
                cmd.adv  = 1'b1;
                put_we   = 1'b1;
                load_out = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cmd.home  = 1'b1;
              state_nxt = ST_SWEEP;
              sw_nxt    = '0;
              sc_nxt    = 1'b0;
              emit_nxt  = 1'b1;
              fill_nxt  = {attr_r, SPACE_CODE};
            end
            MODE_READ: begin
              re        = !oob_in;
              oob_nxt   = oob_in;
              state_nxt = ST_READ;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load_out  = 1'b1;
        rd_cell   = oob_r ? '0 : rdata_r;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        // the read for a sweep index is issued in the cycle before its write
        p_v_nxt = 1'b1;
        p_a_nxt = sw_r;
        p_z_nxt = (sw_r >= AW'(SCROLL_LIM));
        if (sc_r && (sw_r < AW'(SCROLL_LIM))) begin
          re    = 1'b1;
          raddr = AW'(sw_r + AW'(COLUMNS));
        end
        if (sw_r == AW'(CELLS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      ST_FINISH: begin
        p_v_nxt   = 1'b0;
        load_out  = emit_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = load_out;
    out_nxt       = out_r;
    if (load_out) begin
      out_nxt.cursor_position = POS_OUT_W'(pos_nxt);
      out_nxt.cell_value      = rd_cell;
    end
  end

  // single write port: sweep writes from the pipeline, puts at the cursor
  assign we    = put_we || p_v_r;
  assign waddr = p_v_r ? p_a_r : pos_cur;
  always_comb begin
    if (p_v_r) begin
      if (sc_r) begin
        wdata = p_z_r ? '0 : rdata_r;
      end else begin
        wdata = fill_r;
      end
    end else begin
      wdata = {attr_r, in_word.char_code};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_r        <= '0;
      sc_r        <= 1'b0;
      emit_r      <= 1'b0;
      fill_r      <= RESET_CELL;
      p_v_r       <= 1'b0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      sc_r        <= sc_nxt;
      emit_r      <= emit_nxt;
      fill_r      <= fill_nxt;
      p_v_r       <= p_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_a_r <= p_a_nxt;
    p_z_r <= p_z_nxt;
    oob_r <= oob_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // a read word comes back through the memory read register and the output register
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_word.mode == MODE_READ)) |-> ##2 out_valid)
    else $error("read result missing");

  // an ordinary character put answers in the next cycle
  a_put_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_word.mode == MODE_PUT) && !is_nl) |=> out_valid)
    else $error("put result missing");

  // sweep write pipeline only active while sweeping or finishing a sweep
  a_sweep_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> ((state_r == ST_SWEEP) || (state_r == ST_FINISH)))
    else $error("stray sweep write");

  // no result while a sweep is still running
  a_no_out_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) && $past(state_r == ST_SWEEP) |-> !out_valid)
    else $error("result during sweep");

endmodule

`default_nettype wire

// ----- rtl/tcw_cursor.sv -----
// Cursor column/row tracking and linear position for the text console.
// Depends on tcw_pkg (cur_cmd_t, COL_W, ROW_W).
`default_nettype none

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int AW      = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cur_cmd_t      cmd,
  output logic [AW-1:0]      pos_cur,
  output logic [AW-1:0]      pos_nxt,
  output logic               last_row
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]    pos_r;

  assign last_row = (row_r == ROW_W'(ROWS - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.nl) begin
      col_nxt = '0;
      if (!last_row) begin
        row_nxt = row_r + 1'b1;
      end
    end else if (cmd.adv) begin
      if (col_r == COL_W'(COLUMNS - 1)) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // row*COLUMNS + col never reaches the cell count, so AW bits hold it
  assign pos_nxt = AW'(AW'(row_nxt) * AW'(COLUMNS)) + AW'(col_nxt);
  assign pos_cur = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tcw_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for text_console_writer: watches the command, result and attribute ports,
// keeps its own screen and cursor model, and counts mismatched result fields and stray words.
// Depends on tcw_pkg.
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_t               in_word,
  input  logic              out_valid,
  input  out_t              out_word,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data,
  output int                mismatches,
  output int                pending
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [CELL_W-1:0] screen [CELLS];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] attr;
  out_t              status_q [$];
  out_t              oldest;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one command to the screen model and returns the status word it yields.
  function automatic out_t apply_command(input in_t w);
    out_t r;
    int   i;
    r = '0;
    case (mode_t'(w.mode))
      MODE_PUT: begin
        if (w.char_code == NEWLINE_CODE) begin
          if (cur_row >= ROWS - 1) begin
            // scroll: rows move up, bottom row becomes zero cells
            for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
          end else begin
            cur_row++;
          end
          cur_col = 0;
        end else begin
          screen[cur_row * COLUMNS + cur_col] = {attr, w.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) cur_row = 0;
          end
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {attr, SPACE_CODE};
        cur_col = 0;
        cur_row = 0;
      end
      MODE_READ: begin
        if (int'(w.read_address) < CELLS) r.cell_value = screen[w.read_address];
      end
      default: ;
    endcase
    r.cursor_position = POS_OUT_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (screen[i]) screen[i] = RESET_CELL;
      cur_col    = 0;
      cur_row    = 0;
      attr       = RESET_ATTR;
      mismatches = 0;
      status_q.delete();
    end else begin
      if (out_valid) begin
        if (status_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding", int'(out_word), 0);
        end else begin
          oldest = status_q.pop_front();
          if (out_word.cursor_position !== oldest.cursor_position) begin
            report_mismatch("cursor_position", int'(out_word.cursor_position),
                            int'(oldest.cursor_position));
          end
          if (out_word.cell_value !== oldest.cell_value) begin
            report_mismatch("cell_value", int'(out_word.cell_value),
                            int'(oldest.cell_value));
          end
        end
      end
      if (start && !busy) status_q.push_back(apply_command(in_word));
      if (cfg_we) attr = cfg_data;
    end
    pending <= status_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the text_console_writer testbench: clock, reset, command stimulus, watchdog
// and verdict. Depends on tcw_pkg, text_console_writer and tcw_checker.
module tb
  import tcw_pkg::*;
();

  localparam int CELLS           = DEF_COLUMNS * DEF_ROWS;
  localparam int MAX_ADDR        = 2 ** ADDR_IN_W - 1;
  localparam int WATCHDOG_LIMIT  = 12000;
  localparam int TARGET_COMMANDS = 1350;
  localparam int ATTR_PHASE      = 270;
  localparam logic [4:0][ATTR_W-1:0] ATTR_PLAN = {8'h07, 8'hF0, 8'h1E, 8'hA5, 8'h00};

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              start      = 1'b0;
  in_t               in_word    = '0;
  logic              cfg_we     = 1'b0;
  logic [ATTR_W-1:0] cfg_data   = '0;
  logic              busy;
  logic              out_valid;
  out_t              out_word;
  int                mismatches;
  int                pending;
  int                idle_cycles   = 0;
  int                burst_left    = 0;
  int                commands_sent = 0;
  logic [POS_OUT_W-1:0] last_cursor = '0;

  text_console_writer #(
    .COLUMNS(DEF_COLUMNS),
    .ROWS   (DEF_ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  tcw_checker #(
    .COLUMNS(DEF_COLUMNS),
    .ROWS   (DEF_ROWS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // cursor seen on the result side, used only to aim read-back runs
  always @(posedge clk) begin
    if (out_valid) last_cursor <= out_word.cursor_position;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_t make_word(input mode_t m, input logic [CHAR_W-1:0] ch,
                                    input logic [ADDR_IN_W-1:0] addr);
    in_t w;
    w.mode         = m;
    w.char_code    = ch;
    w.read_address = addr;
    return w;
  endfunction

  // Sender works in bursts; before most bursts start drops for a gap before the word.
  task automatic send_word(input in_t w);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (mode_t'(w.mode) != MODE_NONE) commands_sent++;
  endtask

  // Holds off until no result word is outstanding and the block is idle.
  task automatic wait_idle();
    start      <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] a);
    cfg_we   <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                   run_len;
    int                   base;
    int                   kind;
    int                   phase;
    int                   next_phase;
    logic [CHAR_W-1:0]    ch;
    logic [ADDR_IN_W-1:0] addr;
    logic [ATTR_W-1:0]    attr_val;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // reset contents, store bounds and out-of-range reads
    send_word(make_word(MODE_READ, 8'h00, ADDR_IN_W'(0)));
    send_word(make_word(MODE_READ, 8'hFF, ADDR_IN_W'(CELLS - 1)));
    send_word(make_word(MODE_READ, 8'h00, ADDR_IN_W'(CELLS)));
    send_word(make_word(MODE_READ, 8'hFF, ADDR_IN_W'(MAX_ADDR)));
    // character byte extremes, then newline and the unused mode
    send_word(make_word(MODE_PUT, 8'h41, ADDR_IN_W'(MAX_ADDR)));
    send_word(make_word(MODE_PUT, 8'h00, ADDR_IN_W'(0)));
    send_word(make_word(MODE_PUT, 8'hFF, ADDR_IN_W'($urandom)));
    send_word(make_word(MODE_PUT, 8'h80, ADDR_IN_W'($urandom)));
    send_word(make_word(MODE_PUT, 8'h7F, ADDR_IN_W'($urandom)));
    send_word(make_word(MODE_PUT, NEWLINE_CODE, ADDR_IN_W'($urandom)));
    send_word(make_word(MODE_NONE, 8'hFF, ADDR_IN_W'(MAX_ADDR)));
    for (int i = 0; i < 5; i++) begin
      send_word(make_word(MODE_READ, 8'($urandom), ADDR_IN_W'(i)));
    end
    send_word(make_word(MODE_READ, 8'h00, ADDR_IN_W'(DEF_COLUMNS)));
    // full attribute byte, then clear must keep it
    wait_idle();
    set_attribute(8'hFF);
    send_word(make_word(MODE_PUT, 8'h55, ADDR_IN_W'(0)));
    send_word(make_word(MODE_READ, 8'hAA, ADDR_IN_W'(DEF_COLUMNS)));
    send_word(make_word(MODE_CLEAR, 8'hFF, ADDR_IN_W'(MAX_ADDR)));
    send_word(make_word(MODE_READ, 8'h00, ADDR_IN_W'(0)));
    send_word(make_word(MODE_READ, 8'h00, ADDR_IN_W'(CELLS - 1)));

    phase      = 0;
    next_phase = ATTR_PHASE;
    while (commands_sent < TARGET_COMMANDS) begin
      if (commands_sent >= next_phase) begin
        wait_idle();
        attr_val = (phase % 5 == 1) ? ATTR_W'($urandom) : ATTR_PLAN[phase % 5];
        set_attribute(attr_val);
        phase++;
        next_phase += ATTR_PHASE;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // a run of text, long enough at times to wrap rows and the bottom row
        run_len = $urandom_range(1, 90);
        repeat (run_len) begin
          if ($urandom_range(0, 39) == 0) ch = NEWLINE_CODE;
          else if ($urandom_range(0, 3) == 0) ch = CHAR_W'($urandom);
          else ch = CHAR_W'($urandom_range(32, 126));
          send_word(make_word(MODE_PUT, ch, ADDR_IN_W'($urandom)));
        end
      end else if (kind < 65) begin
        // read back the cells just behind the cursor
        run_len = $urandom_range(1, 12);
        base    = int'(last_cursor) - $urandom_range(0, 120);
        if (base < 0) base += CELLS;
        repeat (run_len) begin
          case ($urandom_range(0, 7))
            0:       addr = ADDR_IN_W'($urandom_range(CELLS, MAX_ADDR));
            1:       addr = ADDR_IN_W'($urandom_range(CELLS - DEF_COLUMNS, CELLS - 1));
            2:       addr = ADDR_IN_W'($urandom);
            default: addr = ADDR_IN_W'(base % CELLS);
          endcase
          base++;
          send_word(make_word(MODE_READ, CHAR_W'($urandom), addr));
        end
      end else if (kind < 75) begin
        // newlines push the cursor to the bottom row and then scroll
        run_len = $urandom_range(1, 26);
        repeat (run_len) begin
          send_word(make_word(MODE_PUT, NEWLINE_CODE, ADDR_IN_W'($urandom)));
        end
      end else if (kind < 78) begin
        send_word(make_word(MODE_CLEAR, CHAR_W'($urandom), ADDR_IN_W'($urandom)));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3)) begin
          send_word(make_word(MODE_NONE, CHAR_W'($urandom), ADDR_IN_W'($urandom)));
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       send_word(make_word(MODE_PUT, CHAR_W'($urandom), ADDR_IN_W'($urandom)));
          1:       send_word(make_word(MODE_READ, CHAR_W'($urandom), ADDR_IN_W'($urandom)));
          default: send_word(make_word(MODE_NONE, CHAR_W'($urandom), ADDR_IN_W'($urandom)));
        endcase
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
